### hw/rtl/nca_pkg.sv
// ----------------------------------------------------------------------------
// nca_pkg - shared types and constants for the nearest-centroid assigner
// Item and running-best formats passed along the cell chain, field widths,
// command, operation and register codes.
// ----------------------------------------------------------------------------
package nca_pkg;

    localparam int MAX_CLUSTERS = 20;
    localparam int MAX_DIMS     = 8;
    localparam int COORD_BITS   = 16;

    localparam int CIDX_W = 5;               // cluster_index / best_cluster
    localparam int DIDX_W = 3;               // dim_index
    localparam int NC_W   = 5;               // num_clusters register
    localparam int ND_W   = 4;               // num_dims register
    localparam int CFG_W  = 5;               // widest config register
    localparam int ACC_W  = 36;              // running squared distance
    localparam int DIST_W = 35;              // reported distance
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int IN_W   = CIDX_W + DIDX_W + COORD_BITS;
    localparam int OUT_W  = 40;              // CIDX_W + DIST_W, padded to bytes

    localparam logic [ACC_W-1:0]  ACC_MAX  = {ACC_W{1'b1}};
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // tuser command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // config register indexes
    localparam logic CFG_NUM_CLUSTERS = 1'b0;
    localparam logic CFG_NUM_DIMS     = 1'b1;

    // operation carried down the chain
    typedef logic [1:0] op_t;
    localparam op_t OP_LOAD   = 2'd0;
    localparam op_t OP_SAMPLE = 2'd1;  // intermediate sample coordinate
    localparam op_t OP_LAST   = 2'd2;  // final coordinate, produces a result

    typedef struct packed {
        logic                         valid;
        op_t                          op;
        logic [CIDX_W-1:0]            cidx;
        logic [DIDX_W-1:0]            didx;
        logic signed [COORD_BITS-1:0] value;
    } item_t;

    typedef struct packed {
        logic [CIDX_W-1:0] idx;
        logic [ACC_W-1:0]  dist_sq;
    } best_t;

endpackage

### hw/rtl/nca_cell.sv
// ----------------------------------------------------------------------------
// nca_cell - one centroid of the chain
// Holds one centroid's coordinates and its running distance. Stage 1 squares
// the coordinate difference, stage 2 accumulates and updates the running best.
// ----------------------------------------------------------------------------
module nca_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic [nca_pkg::CIDX_W-1:0] cell_id,
    input  logic [nca_pkg::NC_W-1:0]   num_clusters,
    input  nca_pkg::item_t            item_in,
    input  nca_pkg::best_t            best_in,
    output nca_pkg::item_t            item_out,
    output nca_pkg::best_t            best_out
);
    import nca_pkg::*;

    logic signed [COORD_BITS-1:0] coord_mem [MAX_DIMS];

    logic signed [COORD_BITS-1:0] coord;
    logic [DIFF_W-1:0]            diff;
    logic [DIFF_W-1:0]            mag;
    logic [SQ_W-1:0]              sq;
    logic [ACC_W-1:0]             term_next;

    item_t             item1_reg;
    item_t             item2_reg;
    best_t             best1_reg;
    best_t             best2_reg;
    best_t             best2_next;
    logic [ACC_W-1:0]  term1_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [ACC_W-1:0]  acc_base;
    logic [ACC_W:0]    acc_sum;
    logic [ACC_W-1:0]  acc_new;
    logic              active;
    logic              upd;

    // stage 1: difference and square
    always_comb
    begin
        coord     = coord_mem[item_in.didx];
        diff      = {item_in.value[COORD_BITS-1], item_in.value}
                  - {coord[COORD_BITS-1], coord};
        mag       = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
        sq        = mag * mag;
        term_next = ACC_W'(sq);
    end

    always_ff @(posedge clk)
    begin
        if (en && item_in.valid && item_in.op == OP_LOAD && item_in.cidx == cell_id)
        begin
            coord_mem[item_in.didx] <= item_in.value;
        end
    end

    // stage 2: saturating accumulate, compare against incoming best
    always_comb
    begin
        active   = cell_id < num_clusters;
        upd      = item1_reg.valid && active
                && (item1_reg.op == OP_SAMPLE || item1_reg.op == OP_LAST);
        acc_base = (item1_reg.didx == '0) ? '0 : acc_reg;
        acc_sum  = {1'b0, acc_base} + {1'b0, term1_reg};
        acc_new  = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
        acc_next = upd ? acc_new : acc_reg;
        best2_next = best1_reg;
        if (upd && (cell_id == '0 || acc_new < best1_reg.dist_sq))
        begin
            best2_next.idx     = cell_id;
            best2_next.dist_sq = acc_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item1_reg <= '0;
            item2_reg <= '0;
            acc_reg   <= '0;
        end
        else if (en)
        begin
            item1_reg <= item_in;
            item2_reg <= item1_reg;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            term1_reg <= term_next;
            best1_reg <= best_in;
            best2_reg <= best2_next;
        end
    end

    assign item_out = item2_reg;
    assign best_out = best2_reg;

endmodule

### hw/rtl/nca_out_skid.sv
// ----------------------------------------------------------------------------
// nca_out_skid - result output register with skid stage
// Registered ready towards the chain; the skid entry catches one transfer
// while the receiver stalls.
// ----------------------------------------------------------------------------
module nca_out_skid (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [nca_pkg::OUT_W-1:0] in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [nca_pkg::OUT_W-1:0] out_data
);
    import nca_pkg::*;

    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             sk_valid_reg;
    logic [OUT_W-1:0] sk_data_reg;
    logic             push;
    logic             pop;

    assign in_ready = !sk_valid_reg;
    assign push     = in_valid && !sk_valid_reg;
    assign pop      = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sk_valid_reg  <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_reg <= sk_valid_reg || push;
            sk_valid_reg  <= 1'b0;
        end
        else if (push)
        begin
            sk_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            out_data_reg <= sk_valid_reg ? sk_data_reg : in_data;
        end
        else if (push)
        begin
            sk_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### hw/rtl/nearest_centroid_assign_top.sv
// ----------------------------------------------------------------------------
// nearest_centroid_assign_top - k-means nearest-centroid assignment
// Squared Euclidean distance to up to 20 centroids, lowest index on ties.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream: tuser is the command (0 load centroid coordinate, 1 sample
//   coordinate), tdata carries cluster_index, dim_index and value. Load all
//   centroid coordinates first, then stream each sample's coordinates from
//   dimension 0 upward. The transfer with dim_index = num_dims-1 produces
//   one result on the master stream: best_cluster and best_distance_sq.
//   Loads, intermediate coordinates and coordinates beyond num_dims give none.
//   Config channel: index 0 num_clusters (1..20), index 1 num_dims (1..8,
//   cfg_data[3:0]); values are clamped. Write only while the block is idle.
// Throughput: one transfer per cycle while s_tready is high; every active
//   cell updates its accumulator in parallel as the item walks past.
// Path: the final coordinate reaches m_tvalid through two register stages
//   per centroid cell (20 cells, the first loaded at the edge that takes it)
//   and then the output register.
// Reset: accumulators clear, num_clusters = num_dims = 2, no result pending.
//   Centroid coordinates are undefined until loaded.
// Stall: a skid stage holds one result while m_tready is low; the chain and
//   s_tready then freeze until it drains. s_tready is registered.
// ----------------------------------------------------------------------------
module nearest_centroid_assign_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // slave stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [nca_pkg::IN_W-1:0]      s_tdata,  // [4:0] cluster_index,
                                                    // [7:5] dim_index,
                                                    // [23:8] value
    input  logic                          s_tuser,  // [0] cmd
    // master stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [nca_pkg::OUT_W-1:0]     m_tdata,  // [4:0] best_cluster,
                                                    // [39:5] best_distance_sq
    // config write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [nca_pkg::CFG_W-1:0]     cfg_data
);
    import nca_pkg::*;

    // config registers hold clamped values
    logic [NC_W-1:0] nc_reg;
    logic [NC_W-1:0] nc_next;
    logic [ND_W-1:0] nd_reg;
    logic [ND_W-1:0] nd_next;
    logic [NC_W-1:0] nc_wr;
    logic [ND_W-1:0] nd_wr;

    // input field unpacking
    logic [CIDX_W-1:0]            in_cidx;
    logic [DIDX_W-1:0]            in_didx;
    logic signed [COORD_BITS-1:0] in_value;
    logic                         in_range;
    logic                         in_last;
    logic                         chain_en;
    item_t                        head_item;

    item_t item_chain [MAX_CLUSTERS+1];
    best_t best_chain [MAX_CLUSTERS+1];

    item_t             tail_item;
    best_t             tail_best;
    logic              res_valid;
    logic [DIST_W-1:0] res_dist;
    logic [OUT_W-1:0]  res_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        nc_wr = cfg_data[NC_W-1:0];
        if (nc_wr == '0)
            nc_wr = NC_W'(1);
        else if (nc_wr > NC_W'(MAX_CLUSTERS))
            nc_wr = NC_W'(MAX_CLUSTERS);
        nd_wr = cfg_data[ND_W-1:0];
        if (nd_wr == '0)
            nd_wr = ND_W'(1);
        else if (nd_wr > ND_W'(MAX_DIMS))
            nd_wr = ND_W'(MAX_DIMS);

        nc_next = nc_reg;
        nd_next = nd_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NUM_CLUSTERS: nc_next = nc_wr;
                CFG_NUM_DIMS:     nd_next = nd_wr;
                default:          nc_next = nc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg <= NC_W'(2);
            nd_reg <= ND_W'(2);
        end
        else
        begin
            nc_reg <= nc_next;
            nd_reg <= nd_next;
        end
    end

    // entry: classify the transfer, drop coordinates beyond num_dims
    assign in_cidx  = s_tdata[CIDX_W-1:0];
    assign in_didx  = s_tdata[CIDX_W+DIDX_W-1:CIDX_W];
    assign in_value = s_tdata[IN_W-1:CIDX_W+DIDX_W];
    assign in_range = {1'b0, in_didx} < nd_reg;
    assign in_last  = {1'b0, in_didx} == (nd_reg - 1'b1);
    assign s_tready = chain_en;

    always_comb
    begin
        head_item.valid = s_tvalid && s_tready && (s_tuser == CMD_LOAD || in_range);
        head_item.op    = (s_tuser == CMD_LOAD) ? OP_LOAD
                        : (in_last ? OP_LAST : OP_SAMPLE);
        head_item.cidx  = in_cidx;
        head_item.didx  = in_didx;
        head_item.value = in_value;
    end

    assign item_chain[0] = head_item;
    assign best_chain[0] = '0;

    // one cell per centroid; items and the running best walk down the row
    for (genvar g = 0; g < MAX_CLUSTERS; g++)
    begin : g_cell
        nca_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .en           (chain_en),
            .cell_id      (CIDX_W'(g)),
            .num_clusters (nc_reg),
            .item_in      (item_chain[g]),
            .best_in      (best_chain[g]),
            .item_out     (item_chain[g+1]),
            .best_out     (best_chain[g+1])
        );
    end

    // tail: only the final coordinate of a sample leaves as a result
    assign tail_item = item_chain[MAX_CLUSTERS];
    assign tail_best = best_chain[MAX_CLUSTERS];
    assign res_valid = tail_item.valid && tail_item.op == OP_LAST;
    assign res_dist  = tail_best.dist_sq[ACC_W-1] ? DIST_MAX
                                                  : tail_best.dist_sq[DIST_W-1:0];
    assign res_data  = OUT_W'({res_dist, tail_best.idx});

    nca_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (chain_en),
        .in_data   (res_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

### hw/rtl/nca_checker.sv
// ----------------------------------------------------------------------------
// nca_checker - port-level checks for the nearest-centroid assigner
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
module nca_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [nca_pkg::OUT_W-1:0] m_tdata
);
    import nca_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // index of the winner is always a real centroid
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[CIDX_W-1:0] < CIDX_W'(MAX_CLUSTERS))
        else $error("best_cluster out of range");

    // input back-pressure only while a result is pending at the output
    a_bp_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with no pending result");

    // back-pressure starts only after the receiver stalled a result
    a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("s_tready fell without an output stall");

endmodule

bind nearest_centroid_assign_top nca_checker u_nca_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
